FILE: src/drt_pkg.sv
// Package for the dedup request table: widths, codes, payload structs, controller types.
// Depends on nothing; every other file of the block uses it by scoped names.
`default_nettype none

package drt_pkg;

   localparam int TABLE_DEPTH   = 32;
   localparam int IDX_W         = $clog2(TABLE_DEPTH);
   localparam int CNT_W         = 6;
   localparam int STATION_COUNT = 16;
   localparam int ST_W          = 5;
   localparam int KIND_W        = 2;
   localparam int CMD_W         = 3;
   localparam int STS_W         = 2;
   localparam int FLAG_W        = 3;

   // command codes
   localparam logic [CMD_W-1:0] CMD_PUSH         = 3'd0;
   localparam logic [CMD_W-1:0] CMD_POP_FRONT    = 3'd1;
   localparam logic [CMD_W-1:0] CMD_POP_MATCH    = 3'd2;
   localparam logic [CMD_W-1:0] CMD_QUERY        = 3'd3;
   localparam logic [CMD_W-1:0] CMD_SWEEP_ADD    = 3'd4;
   localparam logic [CMD_W-1:0] CMD_SWEEP_REMOVE = 3'd5;

   // status codes
   localparam logic [STS_W-1:0] STS_DONE  = 2'd0;
   localparam logic [STS_W-1:0] STS_DUP   = 2'd1;
   localparam logic [STS_W-1:0] STS_FULL  = 2'd2;
   localparam logic [STS_W-1:0] STS_EMPTY = 2'd3;

   // request kinds
   localparam logic [KIND_W-1:0] KIND_CW     = 2'd1;
   localparam logic [KIND_W-1:0] KIND_CCW    = 2'd2;
   localparam logic [KIND_W-1:0] KIND_TARGET = 2'd3;

   typedef struct packed {
      logic [CMD_W-1:0]  cmd;
      logic [KIND_W-1:0] req_kind;
      logic [ST_W-1:0]   station;
   } req_type;

   typedef struct packed {
      logic [STS_W-1:0]  status;
      logic              found;
      logic [FLAG_W-1:0] station_flags;
      logic [ST_W-1:0]   popped_station;
      logic [CNT_W-1:0]  entry_count;
      logic [CNT_W-1:0]  sweep_count;
   } rsp_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CMP,
      ST_ACT,
      ST_DONE
   } ctrl_state_type;

   typedef struct packed {
      logic capture;
      logic compare;
      logic apply;
      logic respond;
   } ctrl_cmd_type;

endpackage

`default_nettype wire

FILE: src/drt_ctrl.sv
// Controller for the dedup request table: sequences capture, compare, apply, respond.
// Depends on drt_pkg; drives drt_datapath through a drt_pkg::ctrl_cmd_type struct.
`default_nettype none

module drt_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output drt_pkg::ctrl_cmd_type      ctrl
);

   drt_pkg::ctrl_state_type state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= drt_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      ctrl         = '0;
      req_ready    = 1'b0;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      unique case (state_ff)
         drt_pkg::ST_IDLE: begin
            // take no word while reset is held
            req_ready = ~reset;
            if (req_valid) begin
               ctrl.capture = 1'b1;
               state_in     = drt_pkg::ST_CMP;
            end
         end
         drt_pkg::ST_CMP: begin
            ctrl.compare = 1'b1;
            state_in     = drt_pkg::ST_ACT;
         end
         drt_pkg::ST_ACT: begin
            ctrl.apply = 1'b1;
            state_in   = drt_pkg::ST_DONE;
         end
         drt_pkg::ST_DONE: begin
            // hold until the output word register is free
            if (!rsp_valid_ff || rsp_ready) begin
               ctrl.respond = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = drt_pkg::ST_IDLE;
            end
         end
         default: state_in = drt_pkg::ST_IDLE;
      endcase
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

FILE: src/drt_datapath.sv
// Datapath for the dedup request table: entry table, sweep set, flag store, compare vector.
// Depends on drt_pkg; steered by drt_ctrl through drt_pkg::ctrl_cmd_type.
`default_nettype none

module drt_datapath (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire drt_pkg::ctrl_cmd_type ctrl,
   input  wire drt_pkg::req_type      req_data,
   input  wire logic                  csr_we,
   input  wire logic                  csr_wdata,
   output drt_pkg::rsp_type           rsp_data
);

   localparam int DEPTH = drt_pkg::TABLE_DEPTH;
   localparam int IW    = drt_pkg::IDX_W;
   localparam int CW    = drt_pkg::CNT_W;
   localparam int SW    = drt_pkg::ST_W;
   localparam int KW    = drt_pkg::KIND_W;
   localparam int FW    = drt_pkg::FLAG_W;

   function automatic logic [FW-1:0] kind_bit(input logic [KW-1:0] k);
      logic [FW-1:0] b;
      b = '0;
      unique case (k)
         drt_pkg::KIND_CW:     b = 3'b001;
         drt_pkg::KIND_CCW:    b = 3'b010;
         drt_pkg::KIND_TARGET: b = 3'b100;
         default:              b = '0;
      endcase
      return b;
   endfunction

   function automatic logic station_ok(input logic [SW-1:0] s);
      return (s != '0) && (s <= SW'(drt_pkg::STATION_COUNT));
   endfunction

   logic                        search_mode_ff;
   logic [drt_pkg::CMD_W-1:0]   cmd_ff;
   logic [KW-1:0]               kind_ff;
   logic [SW-1:0]               st_ff;
   logic [SW-1:0]               ent_st_ff   [DEPTH];
   logic [KW-1:0]               ent_kind_ff [DEPTH];
   logic [SW-1:0]               sweep_ff    [DEPTH];
   logic [CW-1:0]               fill_ff, fill_in;
   logic [CW-1:0]               head_ff, head_in;
   logic [CW-1:0]               sweep_fill_ff, sweep_fill_in;
   logic [FW-1:0]               flag_ff [drt_pkg::STATION_COUNT+1];
   logic [DEPTH-1:0]            hit_ff, hit_in;
   logic [SW-1:0]               rd_st_ff;
   logic [KW-1:0]               rd_kind_ff;
   logic [SW-1:0]               sw_rd_ff;
   logic [drt_pkg::STS_W-1:0]   status_ff, status_in;
   logic                        found_ff, found_in;
   logic [SW-1:0]               popped_ff, popped_in;
   drt_pkg::rsp_type            rsp_ff, rsp_in;

   logic [CW-1:0]  start;
   logic [IW-1:0]  rd_idx;
   logic [IW-1:0]  hit_idx;
   logic           hit_any;
   logic           ent_we;
   logic [IW-1:0]  ent_waddr;
   logic [SW-1:0]  ent_wst;
   logic [KW-1:0]  ent_wkind;
   logic           sw_we;
   logic [IW-1:0]  sw_waddr;
   logic [SW-1:0]  sw_wdata;
   logic [SW-1:0]  flag_addr;
   logic [FW-1:0]  flag_cur;
   logic           flag_we;
   logic [FW-1:0]  flag_new;
   logic [CW-1:0]  head_next;
   logic [CW-1:0]  fill_dec;

   // request capture and mode register
   always_ff @(posedge clock) begin
      if (reset) begin
         search_mode_ff <= 1'b0;
      end else if (csr_we) begin
         search_mode_ff <= csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.capture) begin
         cmd_ff  <= req_data.cmd;
         kind_ff <= req_data.req_kind;
         st_ff   <= req_data.station;
      end
   end

   // compare stage: one match vector, selected by command
   assign start  = search_mode_ff ? '0 : head_ff;
   assign rd_idx = (cmd_ff == drt_pkg::CMD_POP_FRONT) ? head_ff[IW-1:0]
                                                      : fill_dec[IW-1:0];
   assign fill_dec = fill_ff - CW'(1);

   always_comb begin
      for (int i = 0; i < DEPTH; i++) begin
         unique case (cmd_ff)
            drt_pkg::CMD_PUSH:
               hit_in[i] = (CW'(i) >= start) && (CW'(i) < fill_ff) &&
                           (ent_st_ff[i] == st_ff) && (ent_kind_ff[i] == kind_ff);
            drt_pkg::CMD_POP_MATCH:
               hit_in[i] = (CW'(i) < fill_ff) &&
                           (ent_st_ff[i] == st_ff) && (ent_kind_ff[i] == kind_ff);
            drt_pkg::CMD_QUERY:
               hit_in[i] = (CW'(i) < fill_ff) && (ent_st_ff[i] == st_ff);
            drt_pkg::CMD_SWEEP_ADD, drt_pkg::CMD_SWEEP_REMOVE:
               hit_in[i] = (CW'(i) < sweep_fill_ff) && (sweep_ff[i] == st_ff);
            default:
               hit_in[i] = 1'b0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.compare) begin
         hit_ff     <= hit_in;
         rd_st_ff   <= ent_st_ff[rd_idx];
         rd_kind_ff <= ent_kind_ff[rd_idx];
         sw_rd_ff   <= sweep_ff[sweep_fill_ff[IW-1:0] - IW'(1)];
      end
   end

   // apply stage
   assign hit_any = |hit_ff;

   always_comb begin
      hit_idx = '0;
      for (int i = DEPTH - 1; i >= 0; i--) begin
         if (hit_ff[i]) begin
            hit_idx = IW'(i);
         end
      end
   end

   assign flag_addr = (ctrl.apply && cmd_ff == drt_pkg::CMD_POP_FRONT) ? rd_st_ff : st_ff;
   assign flag_cur  = station_ok(flag_addr) ? flag_ff[flag_addr] : '0;
   assign head_next = head_ff + CW'(1);

   always_comb begin
      status_in     = drt_pkg::STS_DONE;
      found_in      = 1'b0;
      popped_in     = '0;
      fill_in       = fill_ff;
      head_in       = head_ff;
      sweep_fill_in = sweep_fill_ff;
      ent_we        = 1'b0;
      ent_waddr     = fill_ff[IW-1:0];
      ent_wst       = st_ff;
      ent_wkind     = kind_ff;
      sw_we         = 1'b0;
      sw_waddr      = sweep_fill_ff[IW-1:0];
      sw_wdata      = st_ff;
      flag_we       = 1'b0;
      flag_new      = flag_cur;
      unique case (cmd_ff)
         drt_pkg::CMD_PUSH: begin
            if (hit_any) begin
               status_in = drt_pkg::STS_DUP;
            end else if (fill_ff >= CW'(DEPTH)) begin
               status_in = drt_pkg::STS_FULL;
            end else begin
               ent_we   = 1'b1;
               fill_in  = fill_ff + CW'(1);
               flag_we  = 1'b1;
               flag_new = flag_cur | kind_bit(kind_ff);
            end
         end
         drt_pkg::CMD_POP_FRONT: begin
            if (head_ff >= fill_ff) begin
               status_in = drt_pkg::STS_EMPTY;
            end else begin
               popped_in = rd_st_ff;
               flag_we   = 1'b1;
               flag_new  = flag_cur & ~kind_bit(rd_kind_ff);
               // drained: both counts return to zero
               if (head_next >= fill_ff) begin
                  head_in = '0;
                  fill_in = '0;
               end else begin
                  head_in = head_next;
               end
            end
         end
         drt_pkg::CMD_POP_MATCH: begin
            if (hit_any) begin
               ent_we    = 1'b1;
               ent_waddr = hit_idx;
               ent_wst   = rd_st_ff;
               ent_wkind = rd_kind_ff;
               fill_in   = fill_dec;
               if (head_ff > fill_dec) begin
                  head_in = fill_dec;
               end
            end else begin
               status_in = drt_pkg::STS_EMPTY;
            end
            flag_we  = 1'b1;
            flag_new = flag_cur & ~kind_bit(kind_ff);
         end
         drt_pkg::CMD_QUERY: begin
            found_in = hit_any;
         end
         drt_pkg::CMD_SWEEP_ADD: begin
            if (hit_any) begin
               status_in = drt_pkg::STS_DUP;
            end else if (sweep_fill_ff >= CW'(DEPTH)) begin
               status_in = drt_pkg::STS_FULL;
            end else begin
               sw_we         = 1'b1;
               sweep_fill_in = sweep_fill_ff + CW'(1);
            end
         end
         drt_pkg::CMD_SWEEP_REMOVE: begin
            if (hit_any) begin
               sw_we         = 1'b1;
               sw_waddr      = hit_idx;
               sw_wdata      = sw_rd_ff;
               sweep_fill_in = sweep_fill_ff - CW'(1);
            end else begin
               status_in = drt_pkg::STS_EMPTY;
            end
            flag_we  = 1'b1;
            flag_new = '0;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff       <= '0;
         head_ff       <= '0;
         sweep_fill_ff <= '0;
      end else if (ctrl.apply) begin
         fill_ff       <= fill_in;
         head_ff       <= head_in;
         sweep_fill_ff <= sweep_fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.apply) begin
         status_ff <= status_in;
         found_ff  <= found_in;
         popped_ff <= popped_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.apply && ent_we) begin
         ent_st_ff[ent_waddr]   <= ent_wst;
         ent_kind_ff[ent_waddr] <= ent_wkind;
      end
      if (ctrl.apply && sw_we) begin
         sweep_ff[sw_waddr] <= sw_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s <= drt_pkg::STATION_COUNT; s++) begin
            flag_ff[s] <= '0;
         end
      end else if (ctrl.apply && flag_we && station_ok(flag_addr)) begin
         flag_ff[flag_addr] <= flag_new;
      end
   end

   // output word register
   always_comb begin
      rsp_in.status         = status_ff;
      rsp_in.found          = found_ff;
      rsp_in.station_flags  = flag_cur;
      rsp_in.popped_station = popped_ff;
      rsp_in.entry_count    = fill_ff;
      rsp_in.sweep_count    = sweep_fill_ff;
   end

   always_ff @(posedge clock) begin
      if (ctrl.respond) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_data = rsp_ff;

endmodule

`default_nettype wire

FILE: src/dedup_request_table_top.sv
// Top level of the dedup request table: joins controller and datapath to the ports.
// Depends on drt_pkg, drt_ctrl and drt_datapath.
//
//   channel   ports                       direction   word
//   req       req_valid/req_ready         in          drt_pkg::req_type
//   rsp       rsp_valid/rsp_ready         out         drt_pkg::rsp_type
//   csr       csr_valid/csr_ready         in          search_mode, 1 bit
//
// Each request passes through capture, compare over all table slots at once, apply
// the one table/flag write and load the output word before the next request is
// accepted. The single write port of each store sets that order.
// Synchronous reset clears counts, flags and mode; table slots need no clearing.
// A stalled rsp holds the next result in the done state; a new request is still
// accepted while an earlier result waits in the output register.
`default_nettype none

module dedup_request_table_top (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire drt_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output drt_pkg::rsp_type      rsp_data,
   input  wire logic             csr_valid,
   output logic                  csr_ready,
   input  wire logic             csr_wdata
);

   drt_pkg::ctrl_cmd_type ctrl;

   assign csr_ready = ~reset;

   drt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .ctrl      (ctrl)
   );

   drt_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (ctrl),
      .req_data  (req_data),
      .csr_we    (csr_valid & csr_ready),
      .csr_wdata (csr_wdata),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

FILE: dv/tb_dedup_request_table_top.sv
`timescale 1ns / 100ps
// Self-checking testbench for dedup_request_table_top: random and directed commands
// with random idling on the req and rsp channels, checked against an in-bench table predictor.
// Depends on drt_pkg and the RTL of the block.

module tb_dedup_request_table_top;

   localparam logic [drt_pkg::CMD_W-1:0]  CMD_SPARE_LO       = 3'd6;
   localparam logic [drt_pkg::CMD_W-1:0]  CMD_SPARE_HI       = 3'd7;
   localparam logic [drt_pkg::KIND_W-1:0] KIND_NONE          = 2'd0;
   localparam logic                       MODE_FIRST_COME    = 1'b0;
   localparam logic                       MODE_SHORTEST_SEEK = 1'b1;
   localparam int                         LONG_HOLD          = 300;
   localparam int                         IDLE_LIMIT         = 2000;
   localparam int                         SETTLE_CYCLES      = 10;
   localparam int                         PHASE_ITEMS        = 105;
   localparam int                         REQ_W              = $bits(drt_pkg::req_type);

   // Mirror of the request table, its flags and the sweep set.
   class request_table_scoreboard;
      logic [drt_pkg::ST_W-1:0]   slot_station[drt_pkg::TABLE_DEPTH];
      logic [drt_pkg::KIND_W-1:0] slot_kind[drt_pkg::TABLE_DEPTH];
      logic [drt_pkg::ST_W-1:0]   sweep_members[drt_pkg::TABLE_DEPTH];
      logic [drt_pkg::FLAG_W-1:0] flags[drt_pkg::STATION_COUNT+1];
      int                         fill;
      int                         head;
      int                         sweep_fill;
      logic                       mode;
      drt_pkg::rsp_type           expected_q[$];
      int                         errors;

      function new();
         foreach (flags[i]) flags[i] = '0;
         fill       = 0;
         head       = 0;
         sweep_fill = 0;
         mode       = MODE_FIRST_COME;
         errors     = 0;
      endfunction

      function void set_mode(logic m);
         mode = m;
      endfunction

      function int pending();
         return expected_q.size();
      endfunction

      function bit station_ok(logic [drt_pkg::ST_W-1:0] st);
         return st >= 1 && st <= drt_pkg::STATION_COUNT;
      endfunction

      function logic [drt_pkg::FLAG_W-1:0] kind_mask(logic [drt_pkg::KIND_W-1:0] kind);
         if (kind == KIND_NONE) return '0;
         return drt_pkg::FLAG_W'(1) << (kind - 1);
      endfunction

      function int find_pair(int start, logic [drt_pkg::ST_W-1:0] st,
                             logic [drt_pkg::KIND_W-1:0] kind);
         for (int i = start; i < fill; i++)
            if (slot_station[i] == st && slot_kind[i] == kind) return i;
         return fill;
      endfunction

      function int find_sweep(logic [drt_pkg::ST_W-1:0] st);
         for (int i = 0; i < sweep_fill; i++)
            if (sweep_members[i] == st) return i;
         return sweep_fill;
      endfunction

      function void note_request(drt_pkg::req_type r);
         drt_pkg::rsp_type e;
         int               pos;
         e   = '0;
         pos = 0;
         case (r.cmd)
            drt_pkg::CMD_PUSH: begin
               pos = find_pair((mode == MODE_FIRST_COME) ? head : 0, r.station, r.req_kind);
               if (pos < fill) e.status = drt_pkg::STS_DUP;
               else if (fill >= drt_pkg::TABLE_DEPTH) e.status = drt_pkg::STS_FULL;
               else begin
                  if (station_ok(r.station)) flags[r.station] |= kind_mask(r.req_kind);
                  slot_station[fill] = r.station;
                  slot_kind[fill]    = r.req_kind;
                  fill++;
               end
            end
            drt_pkg::CMD_POP_FRONT: begin
               if (head >= fill) e.status = drt_pkg::STS_EMPTY;
               else begin
                  e.popped_station = slot_station[head];
                  if (station_ok(slot_station[head]))
                     flags[slot_station[head]] &= ~kind_mask(slot_kind[head]);
                  head++;
                  // the head caught up: the table starts over
                  if (head >= fill) begin
                     head = 0;
                     fill = 0;
                  end
               end
            end
            drt_pkg::CMD_POP_MATCH: begin
               pos = find_pair(0, r.station, r.req_kind);
               if (pos < fill) begin
                  slot_station[pos] = slot_station[fill-1];
                  slot_kind[pos]    = slot_kind[fill-1];
                  fill--;
                  if (head > fill) head = fill;
               end else e.status = drt_pkg::STS_EMPTY;
               if (station_ok(r.station)) flags[r.station] &= ~kind_mask(r.req_kind);
            end
            drt_pkg::CMD_QUERY: begin
               for (int i = 0; i < fill; i++)
                  if (slot_station[i] == r.station) e.found = 1'b1;
            end
            drt_pkg::CMD_SWEEP_ADD: begin
               if (find_sweep(r.station) < sweep_fill) e.status = drt_pkg::STS_DUP;
               else if (sweep_fill >= drt_pkg::TABLE_DEPTH) e.status = drt_pkg::STS_FULL;
               else begin
                  sweep_members[sweep_fill] = r.station;
                  sweep_fill++;
               end
            end
            drt_pkg::CMD_SWEEP_REMOVE: begin
               pos = find_sweep(r.station);
               if (pos < sweep_fill) begin
                  sweep_members[pos] = sweep_members[sweep_fill-1];
                  sweep_fill--;
               end else e.status = drt_pkg::STS_EMPTY;
               if (station_ok(r.station)) flags[r.station] = '0;
            end
            default: ;
         endcase
         e.station_flags = station_ok(r.station) ? flags[r.station] : '0;
         e.entry_count   = drt_pkg::CNT_W'(fill);
         e.sweep_count   = drt_pkg::CNT_W'(sweep_fill);
         expected_q      = {expected_q, e};
      endfunction

      task report_mismatch(string msg);
         $display("%0t ns: mismatch: %s", $time, msg);
         errors++;
      endtask

      task compare_field(string name, logic [7:0] got, logic [7:0] want);
         if (got !== want)
            report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
      endtask

      task check_result(drt_pkg::rsp_type got);
         drt_pkg::rsp_type want;
         if (expected_q.size() == 0) begin
            report_mismatch($sformatf("result word %h with nothing outstanding", got));
         end else begin
            want = expected_q.pop_front();
            compare_field("status", 8'(got.status), 8'(want.status));
            compare_field("found", 8'(got.found), 8'(want.found));
            compare_field("station_flags", 8'(got.station_flags), 8'(want.station_flags));
            compare_field("popped_station", 8'(got.popped_station),
                          8'(want.popped_station));
            compare_field("entry_count", 8'(got.entry_count), 8'(want.entry_count));
            compare_field("sweep_count", 8'(got.sweep_count), 8'(want.sweep_count));
         end
      endtask
   endclass

   logic             clock     = 1'b0;
   logic             reset     = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_ready;
   drt_pkg::req_type req_data  = '0;
   logic             rsp_valid;
   logic             rsp_ready = 1'b0;
   drt_pkg::rsp_type rsp_data;
   logic             csr_valid = 1'b0;
   logic             csr_ready;
   logic             csr_wdata = 1'b0;

   request_table_scoreboard table_sb = new();

   // knobs for the sender and the receiver, and the idle counter of the watchdog
   bit quiet         = 1'b0;
   int stall_pct     = 20;
   int hold_requests = 0;
   int idle_cycles   = 0;

   always #5 clock = ~clock;

   dedup_request_table_top uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_wdata (csr_wdata)
   );

   // mostly short gaps, now and then a long one
   function int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function drt_pkg::req_type mk(logic [drt_pkg::CMD_W-1:0] c,
                                 logic [drt_pkg::KIND_W-1:0] k,
                                 logic [drt_pkg::ST_W-1:0] s);
      drt_pkg::req_type r;
      r.cmd      = c;
      r.req_kind = k;
      r.station  = s;
      return r;
   endfunction

   task send_request(drt_pkg::req_type r);
      int gap;
      gap = quiet ? 0 : pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      table_sb.note_request(r);
   endtask

   // drop valid and let every outstanding word come back
   task drain();
      req_valid <= 1'b0;
      while (table_sb.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task write_mode(logic m);
      csr_valid <= 1'b1;
      csr_wdata <= m;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      table_sb.set_mode(m);
   endtask

   task run_phase(logic m, int pool, int wts[6], bit no_gaps, int stall, bit squeeze);
      logic [drt_pkg::CMD_W-1:0] cmds[6];
      drt_pkg::req_type          r;
      int                        total;
      int                        pick;
      cmds  = '{drt_pkg::CMD_PUSH, drt_pkg::CMD_POP_FRONT, drt_pkg::CMD_POP_MATCH,
                drt_pkg::CMD_QUERY, drt_pkg::CMD_SWEEP_ADD, drt_pkg::CMD_SWEEP_REMOVE};
      total = 0;
      foreach (wts[i]) total += wts[i];
      drain();
      write_mode(m);
      quiet     = no_gaps;
      stall_pct = stall;
      if (squeeze) hold_requests++;
      repeat (PHASE_ITEMS) begin
         if ($urandom_range(0, 99) < 6) begin
            r = REQ_W'($urandom_range(0, 1023));
         end else begin
            pick = $urandom_range(0, total - 1);
            r.cmd = cmds[5];
            for (int i = 0; i < 6; i++) begin
               if (pick < wts[i]) begin
                  r.cmd = cmds[i];
                  break;
               end
               pick -= wts[i];
            end
            r.req_kind = drt_pkg::KIND_W'($urandom_range(drt_pkg::KIND_CW,
                                                         drt_pkg::KIND_TARGET));
            r.station  = (pool >= 32) ? drt_pkg::ST_W'($urandom_range(0, 31))
                                      : drt_pkg::ST_W'($urandom_range(1, pool));
         end
         send_request(r);
      end
   endtask

   initial begin : stimulus
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      write_mode(MODE_FIRST_COME);

      // empty table, duplicates, odd stations and kinds, match below head, sweep set, spare codes
      send_request(mk(drt_pkg::CMD_POP_FRONT, drt_pkg::KIND_CW, 5'd1));
      send_request(mk(drt_pkg::CMD_POP_MATCH, drt_pkg::KIND_CW, 5'd2));
      send_request(mk(drt_pkg::CMD_SWEEP_REMOVE, drt_pkg::KIND_CW, 5'd3));
      send_request(mk(drt_pkg::CMD_PUSH, drt_pkg::KIND_CW, 5'd1));
      send_request(mk(drt_pkg::CMD_PUSH, drt_pkg::KIND_CW, 5'd1));
      send_request(mk(drt_pkg::CMD_PUSH, drt_pkg::KIND_TARGET, 5'd16));
      send_request(mk(drt_pkg::CMD_PUSH, KIND_NONE, 5'd0));
      send_request(mk(drt_pkg::CMD_PUSH, drt_pkg::KIND_TARGET, 5'd31));
      send_request(mk(drt_pkg::CMD_QUERY, drt_pkg::KIND_CW, 5'd1));
      send_request(mk(drt_pkg::CMD_QUERY, drt_pkg::KIND_CW, 5'd5));
      send_request(mk(drt_pkg::CMD_POP_FRONT, drt_pkg::KIND_CW, 5'd0));
      send_request(mk(drt_pkg::CMD_PUSH, drt_pkg::KIND_CW, 5'd1));
      send_request(mk(drt_pkg::CMD_POP_MATCH, drt_pkg::KIND_TARGET, 5'd31));
      send_request(mk(drt_pkg::CMD_POP_MATCH, drt_pkg::KIND_TARGET, 5'd16));
      send_request(mk(drt_pkg::CMD_POP_FRONT, drt_pkg::KIND_CW, 5'd0));
      send_request(mk(drt_pkg::CMD_POP_MATCH, drt_pkg::KIND_CW, 5'd1));
      send_request(mk(drt_pkg::CMD_POP_MATCH, drt_pkg::KIND_CW, 5'd1));
      send_request(mk(drt_pkg::CMD_POP_FRONT, drt_pkg::KIND_CW, 5'd0));
      send_request(mk(drt_pkg::CMD_SWEEP_ADD, drt_pkg::KIND_CW, 5'd16));
      send_request(mk(drt_pkg::CMD_SWEEP_ADD, drt_pkg::KIND_CW, 5'd16));
      send_request(mk(drt_pkg::CMD_SWEEP_ADD, drt_pkg::KIND_CCW, 5'd0));
      send_request(mk(drt_pkg::CMD_SWEEP_REMOVE, drt_pkg::KIND_CCW, 5'd16));
      send_request(mk(CMD_SPARE_LO, KIND_NONE, 5'd0));
      send_request(mk(CMD_SPARE_HI, drt_pkg::KIND_TARGET, 5'd31));
      send_request(mk(drt_pkg::CMD_PUSH, drt_pkg::KIND_CCW, 5'd16));

      //        mode                pool  push popf popm qry sadd srem  quiet stall squeeze
      run_phase(MODE_FIRST_COME,    4,  '{30, 20, 15, 15, 10, 10}, 1'b0, 20, 1'b0);
      run_phase(MODE_SHORTEST_SEEK, 16, '{80,  5,  5,  5,  3,  2}, 1'b1, 10, 1'b1);
      run_phase(MODE_FIRST_COME,    16, '{25, 40, 20, 10,  3,  2}, 1'b0, 30, 1'b0);
      run_phase(MODE_SHORTEST_SEEK, 6,  '{30, 20, 20, 10, 10, 10}, 1'b1,  0, 1'b0);
      run_phase(MODE_FIRST_COME,    32, '{10,  5,  5,  5, 60, 15}, 1'b0, 20, 1'b0);
      run_phase(MODE_SHORTEST_SEEK, 4,  '{35, 25, 15, 10,  8,  7}, 1'b0, 40, 1'b0);
      run_phase(MODE_FIRST_COME,    16, '{50, 10, 30, 10,  0,  0}, 1'b0, 15, 1'b0);

      drain();
      if (table_sb.pending() != 0)
         table_sb.report_mismatch($sformatf("%0d results never came", table_sb.pending()));
      if (table_sb.errors == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   initial begin : rsp_sink
      int stall_left;
      int holds_done;
      stall_left = 0;
      holds_done = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready) table_sb.check_result(rsp_data);
         if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else if (holds_done < hold_requests) begin
            // hold off long enough for the block to back up into its input
            holds_done++;
            stall_left = LONG_HOLD - 1;
            rsp_ready <= 1'b0;
         end else if ($urandom_range(0, 99) < stall_pct) begin
            stall_left = pick_gap();
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("%0t ns: no word moved for %0d cycles", $time, IDLE_LIMIT);
         $display("Testbench completed WITH ERRORS");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

endmodule

FILE: dedup_request_table_top.f
src/drt_pkg.sv
src/drt_ctrl.sv
src/drt_datapath.sv
src/dedup_request_table_top.sv
dv/tb_dedup_request_table_top.sv
